// ===== rtl/core/first_fit_block_allocator_top_assert.svh =====
// Assertion macros shared by the first-fit block allocator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define FFBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/ffba_pkg.sv =====
// Package for the first-fit block allocator: field layout, codes,
// controller states and the command/status structs. No dependencies.
package ffba_pkg;

    localparam int INDEX_FIELD_W     = 4;
    localparam int SIZE_FIELD_W      = 16;
    localparam int COUNT_W           = 5;
    localparam int BLOCK_COUNT_RESET = 16;

    localparam int S_INDEX_LSB = 0;
    localparam int S_BSIZE_LSB = S_INDEX_LSB + INDEX_FIELD_W;
    localparam int S_RSIZE_LSB = S_BSIZE_LSB + SIZE_FIELD_W;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } ffba_state_t;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic scan;
        logic capture;
        logic emit;
    } ffba_cmd_t;

    typedef struct packed {
        logic is_request;
        logic zero_limit;
        logic hit;
        logic last;
        logic out_free;
    } ffba_status_t;

endpackage

// ===== rtl/core/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
// Depends on ffba_pkg; drives commands into ffba_datapath.
module ffba_ctrl import ffba_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ffba_status_t status,
    output ffba_cmd_t    cmd
);

    ffba_state_t state_reg;
    ffba_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (status.is_request) begin
                        cmd.start = 1'b1;
                        if (status.zero_limit) begin
                            cmd.capture = 1'b1;
                            state_next  = ST_EMIT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.hit || status.last) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ffba_datapath.sv =====
// Datapath of the first-fit block allocator: size memory, allocated marks,
// scan pipeline, result and output registers. Depends on ffba_pkg.
`include "first_fit_block_allocator_top_assert.svh"

module ffba_datapath import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic [COUNT_W-1:0]   cfg_data,
    input  ffba_cmd_t            cmd,
    output ffba_status_t         status
);

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int LIM_RAW = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W   = (LIM_RAW > COUNT_W) ? LIM_RAW : COUNT_W;

    logic [INDEX_FIELD_W-1:0] in_index;
    logic [SIZE_FIELD_W-1:0]  in_bsize;
    logic [SIZE_FIELD_W-1:0]  in_rsize;
    logic [IDX_W-1:0]         load_addr;
    logic                     load_in_range;

    logic [COUNT_W-1:0]       count_reg;
    logic [LIM_W-1:0]         limit;

    logic [SIZE_BITS-1:0]     sizes_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]    marks_reg;
    logic [SIZE_BITS-1:0]     rd_data_reg;
    logic [SIZE_BITS-1:0]     want_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         chk_idx_reg;
    logic                     chk_valid_reg;
    logic                     hit;
    logic                     hit_q;
    logic                     last;

    logic                     res_granted_reg;
    logic [INDEX_FIELD_W-1:0] res_index_reg;
    logic [SIZE_FIELD_W-1:0]  res_size_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tuser_reg;
    logic                     out_free;

    assign in_index      = s_tdata[S_INDEX_LSB +: INDEX_FIELD_W];
    assign in_bsize      = s_tdata[S_BSIZE_LSB +: SIZE_FIELD_W];
    assign in_rsize      = s_tdata[S_RSIZE_LSB +: SIZE_FIELD_W];
    assign load_addr     = IDX_W'(in_index);
    assign load_in_range = LIM_W'(in_index) < LIM_W'(MAX_BLOCKS);

    assign limit = (LIM_W'(count_reg) > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS)
                                                             : LIM_W'(count_reg);

    assign hit   = chk_valid_reg && !marks_reg[chk_idx_reg] && (rd_data_reg >= want_reg);
    assign hit_q = cmd.scan && hit;
    assign last  = chk_valid_reg && (LIM_W'(chk_idx_reg) == (limit - LIM_W'(1)));

    assign out_free = !m_tvalid_reg || m_tready;

    assign status.is_request = (s_tuser == OP_REQUEST);
    assign status.zero_limit = (limit == '0);
    assign status.hit        = hit;
    assign status.last       = last;
    assign status.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_W'(BLOCK_COUNT_RESET);
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_in_range) begin
            sizes_mem[load_addr] <= SIZE_BITS'(in_bsize);
        end
        rd_data_reg <= sizes_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
        end else if (cmd.load_wr && load_in_range) begin
            marks_reg[load_addr] <= 1'b0;
        end else if (cmd.capture && hit_q) begin
            marks_reg[chk_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else if (cmd.start) begin
            chk_valid_reg <= 1'b0;
        end else if (cmd.scan) begin
            chk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            idx_reg  <= '0;
            want_reg <= SIZE_BITS'(in_rsize);
        end else if (cmd.scan) begin
            idx_reg     <= idx_reg + IDX_W'(1);
            chk_idx_reg <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_granted_reg <= hit_q;
            res_index_reg   <= hit_q ? INDEX_FIELD_W'(chk_idx_reg) : '0;
            res_size_reg    <= hit_q ? SIZE_FIELD_W'(rd_data_reg) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({res_size_reg, res_index_reg});
            m_tuser_reg <= res_granted_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FFBA_ASSERT_NEXT(a_hit_sets_mark, aclk, aresetn, cmd.scan && hit, marks_reg[$past(chk_idx_reg)])
    `FFBA_ASSERT_IMPLIES(a_emit_needs_slot, aclk, aresetn, cmd.emit, out_free)
    `FFBA_ASSERT_IMPLIES(a_scan_in_limit, aclk, aresetn, cmd.scan && chk_valid_reg, LIM_W'(chk_idx_reg) < limit)

endmodule

// ===== rtl/core/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  s_       | in        | s_tvalid / s_tready | tuser: operation; tdata: index,
//           |           |                     |   block size, request size
//  m_       | out       | m_tvalid / m_tready | tuser: granted; tdata: index, size
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_data: block_count
//
// A load is written in the idle state, which then takes the next beat. A request scans entries
// 0 to L-1 with L = min(block_count, MAX_BLOCKS) until a free block fits; if L is 0 it misses at once.
// The scan reads one size memory entry per cycle.
// Synchronous active-low reset clears marks, state and block_count (to 16).
// A result held on m_ lets the next request scan, then holds it in emit and stalls s_.
module first_fit_block_allocator_top import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] block_index, [19:4] block_size_value,
                                            // [35:20] request_size, [39:36] zero
    input  logic                 s_tuser,   // [0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [3:0] granted_index, [19:4] granted_block_size,
                                            // [23:20] zero
    output logic                 m_tuser,   // [0] granted
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COUNT_W-1:0]   cfg_data
);

    ffba_cmd_t    cmd;
    ffba_status_t status;

    assign cfg_ready = 1'b1;

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
